// File: sv/mmcpn_pkg.sv
// Shared types and constants for the masked max cross-product norm unit.
// Used by mmcpn_ctrl, mmcpn_datapath and masked_max_cross_product_norm_unit.
package mmcpn_pkg;

    // Field widths fixed by the interface
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int IN_W               = 16;
    localparam int OUT_W              = 32;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[2])
    localparam logic REG_MAG_EN = 1'b0;
    localparam logic REG_FRZ_EN = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CROSS,
        ST_SQUARE,
        ST_SUM,
        ST_UPDATE,
        ST_ROOT,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;     // capture products, mask decision and last flag
        logic xprod;      // form cross-product magnitudes
        logic square;     // square the magnitudes
        logic sum;        // add the three squares
        logic update;     // fold sum into running maximum
        logic root_load;  // load square-root unit from updated maximum
        logic root_step;  // one two-bit step of the square root
        logic emit;       // load output register and clear running state
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last;       // request in flight is the last of its set
    } sts_t;

endpackage

// File: sv/mmcpn_datapath.sv
// Datapath: products, cross product, squared norm, running maximum,
// iterative square root and output register. Depends on mmcpn_pkg.
module mmcpn_datapath
    import mmcpn_pkg::*;
#(
    parameter int CB = COMPONENT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              mag_en,
    input  logic              frz_en,
    input  logic [IN_W-1:0]   a_x,
    input  logic [IN_W-1:0]   a_y,
    input  logic [IN_W-1:0]   a_z,
    input  logic [IN_W-1:0]   b_x,
    input  logic [IN_W-1:0]   b_y,
    input  logic [IN_W-1:0]   b_z,
    input  logic              is_magnetic,
    input  logic              is_frozen,
    input  logic              last_node,
    output logic [OUT_W-1:0]  max_norm,
    output logic              any_counted
);

    localparam int PW = 2 * CB;      // product / magnitude / root width
    localparam int XW = PW + 1;      // cross component width (signed)
    localparam int SW = 4 * CB;      // squared norm width
    localparam int AW = SW + 2;      // sum width before truncation
    localparam int RW = PW + 2;      // root remainder width

    // Components taken from the low CB bits, sign-extended
    logic signed [CB-1:0] ax, ay, az, bx, by, bz;
    assign ax = a_x[CB-1:0];
    assign ay = a_y[CB-1:0];
    assign az = a_z[CB-1:0];
    assign bx = b_x[CB-1:0];
    assign by = b_y[CB-1:0];
    assign bz = b_z[CB-1:0];

    // Stage 1: six partial products of the cross product
    logic signed [PW-1:0] p_reg [6];
    logic                 skip_reg;
    logic                 last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            p_reg[0] <= PW'(ay) * PW'(bz);
            p_reg[1] <= PW'(az) * PW'(by);
            p_reg[2] <= PW'(az) * PW'(bx);
            p_reg[3] <= PW'(ax) * PW'(bz);
            p_reg[4] <= PW'(ax) * PW'(by);
            p_reg[5] <= PW'(ay) * PW'(bx);
            skip_reg <= (mag_en & ~is_magnetic) | (frz_en & is_frozen);
            last_reg <= last_node;
        end
    end

    assign sts.last = last_reg;

    // Stage 2: cross-product components as magnitudes
    logic signed [XW-1:0] c_diff [3];
    logic        [XW-1:0] c_abs  [3];
    logic        [PW-1:0] mag_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_diff[i] = XW'(p_reg[2*i]) - XW'(p_reg[2*i+1]);
            c_abs[i]  = c_diff[i][XW-1] ? XW'(-c_diff[i]) : XW'(c_diff[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.xprod) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= c_abs[i][PW-1:0];
            end
        end
    end

    // Stage 3: squares
    logic [SW-1:0] sq_reg [3];

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SW'(mag_reg[i]) * SW'(mag_reg[i]);
            end
        end
    end

    // Stage 4: squared norm (always below 2^SW)
    logic [AW-1:0] sum_wide;
    logic [SW-1:0] sum_reg;

    assign sum_wide = AW'(sq_reg[0]) + AW'(sq_reg[1]) + AW'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            sum_reg <= sum_wide[SW-1:0];
        end
    end

    // Running maximum and counted flag
    logic [SW-1:0] best_reg, best_next;
    logic          seen_reg, seen_next;

    always_comb begin
        best_next = best_reg;
        seen_next = seen_reg;
        if (cmd.emit) begin
            best_next = '0;
            seen_next = 1'b0;
        end else if (cmd.update && !skip_reg) begin
            seen_next = 1'b1;
            if (sum_reg > best_reg) begin
                best_next = sum_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= '0;
            seen_reg <= 1'b0;
        end else begin
            best_reg <= best_next;
            seen_reg <= seen_next;
        end
    end

    // Square root, two radicand bits per step
    logic [SW-1:0] rad_reg;
    logic [RW-1:0] rem_reg;
    logic [PW-1:0] root_reg;
    logic          root_seen_reg;
    logic [RW-1:0] rem_shift;
    logic [RW-1:0] trial;
    logic          fits;

    assign rem_shift = {rem_reg[PW-1:0], rad_reg[SW-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = rem_shift >= trial;

    always_ff @(posedge aclk) begin
        if (cmd.root_load) begin
            rad_reg       <= best_next;
            rem_reg       <= '0;
            root_reg      <= '0;
            root_seen_reg <= seen_next;
        end else if (cmd.root_step) begin
            rad_reg  <= {rad_reg[SW-3:0], 2'b00};
            rem_reg  <= fits ? rem_shift - trial : rem_shift;
            root_reg <= {root_reg[PW-2:0], fits};
        end
    end

    // Output register
    logic [OUT_W-1:0] max_norm_reg;
    logic             any_counted_reg;

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            max_norm_reg    <= root_seen_reg ? OUT_W'(root_reg) : '0;
            any_counted_reg <= root_seen_reg;
        end
    end

    assign max_norm    = max_norm_reg;
    assign any_counted = any_counted_reg;

endmodule

// File: sv/mmcpn_ctrl.sv
// Controller: sequences one request through the datapath, runs the
// square-root steps and owns both handshakes. Depends on mmcpn_pkg.
module mmcpn_ctrl
    import mmcpn_pkg::*;
#(
    parameter int CB = COMPONENT_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int ROOT_STEPS = 2 * CB;
    localparam int CNT_W      = $clog2(ROOT_STEPS + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_CROSS;
            ST_CROSS:  state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_UPDATE;
            ST_UPDATE: state_next = sts.last ? ST_ROOT : ST_IDLE;
            ST_ROOT:   if (cnt_reg == CNT_W'(1)) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_CROSS:  cmd.xprod  = 1'b1;
            ST_SQUARE: cmd.square = 1'b1;
            ST_SUM:    cmd.sum    = 1'b1;
            ST_UPDATE: begin
                cmd.update    = 1'b1;
                cmd.root_load = sts.last;
            end
            ST_ROOT:   cmd.root_step = 1'b1;
            ST_EMIT:   cmd.emit      = out_free;
            default: ;
        endcase
    end

    // Root step counter
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.root_load) begin
            cnt_next = CNT_W'(ROOT_STEPS);
        end else if (cmd.root_step) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Output valid: set on load, cleared when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

`ifndef ASSERT_OFF
    // One request at a time: no accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one in flight");

    // Root unit starts with a full step count
    a_root_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.root_load |=> (state_reg == ST_ROOT) && (cnt_reg == CNT_W'(ROOT_STEPS)))
        else $error("square root not started correctly");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_ready))
        else $error("output register overwritten");

    // A result appears only after the emit step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result shown without emit");
`endif

endmodule

// File: sv/masked_max_cross_product_norm_unit.sv
// Top level of the masked max cross-product norm unit: register port,
// controller and datapath. Depends on mmcpn_pkg, mmcpn_ctrl, mmcpn_datapath.
//
// Usage:
//   Input channel s_*: one mesh node per request, two signed 3-vectors plus
//   magnetic, frozen and last flags. Nodes removed by the enabled masks are
//   skipped. Result channel m_*: one result per set, on its last node,
//   carrying floor(sqrt(max |a x b|^2)) and whether any node counted.
//   Register port: offset 0 magnetic mask enable, offset 4 frozen mask
//   enable (bit 0); write only while the unit is idle.
// Timing:
//   A node is worked on alone: s_ready is high only in the idle state, so a
//   node steps through accept, cross, square, sum and update first. A last node
//   adds 2*COMPONENT_BITS square-root steps (32 at the default) and an emit
//   step, set by the two-bit-per-step root unit; the result shows on m_valid
//   the cycle after emit.
// Reset and stalls:
//   Reset clears the running maximum, the mask enables and the output valid.
//   The result sits in an output register; the next set is accepted while it
//   waits, and only a following result waits in the emit state for m_ready.
module masked_max_cross_product_norm_unit
    import mmcpn_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // APB-style register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // Input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [IN_W-1:0]     s_a_x,
    input  logic [IN_W-1:0]     s_a_y,
    input  logic [IN_W-1:0]     s_a_z,
    input  logic [IN_W-1:0]     s_b_x,
    input  logic [IN_W-1:0]     s_b_y,
    input  logic [IN_W-1:0]     s_b_z,
    input  logic                s_is_magnetic,
    input  logic                s_is_frozen,
    input  logic                s_last_node,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OUT_W-1:0]    m_max_norm,
    output logic                m_any_counted
);

    cmd_t cmd;
    sts_t sts;

    // Configuration registers
    logic mag_en_reg, mag_en_next;
    logic frz_en_reg, frz_en_next;
    logic reg_sel;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        mag_en_next = mag_en_reg;
        frz_en_next = frz_en_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_MAG_EN: mag_en_next = pwdata[0];
                REG_FRZ_EN: frz_en_next = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_en_reg <= 1'b0;
            frz_en_reg <= 1'b0;
        end else begin
            mag_en_reg <= mag_en_next;
            frz_en_reg <= frz_en_next;
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_MAG_EN: prdata[0] = mag_en_reg;
            REG_FRZ_EN: prdata[0] = frz_en_reg;
            default: ;
        endcase
    end

    mmcpn_ctrl #(
        .CB (COMPONENT_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mmcpn_datapath #(
        .CB (COMPONENT_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .mag_en      (mag_en_reg),
        .frz_en      (frz_en_reg),
        .a_x         (s_a_x),
        .a_y         (s_a_y),
        .a_z         (s_a_z),
        .b_x         (s_b_x),
        .b_y         (s_b_y),
        .b_z         (s_b_z),
        .is_magnetic (s_is_magnetic),
        .is_frozen   (s_is_frozen),
        .last_node   (s_last_node),
        .max_norm    (m_max_norm),
        .any_counted (m_any_counted)
    );

endmodule

// File: bench/masked_max_cross_product_norm_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for masked_max_cross_product_norm_unit: streams node sets
// under all mask settings and idling patterns. Depends on mmcpn_pkg and the unit RTL.
module masked_max_cross_product_norm_unit_tb;
    import mmcpn_pkg::*;

    localparam int COMP_BITS   = COMPONENT_BITS_DEF;
    localparam int SETTLE      = 48;       // outlasts the root steps, emit and output stage
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_BUDGET = 108;      // minimum requests per random phase

    // One node request and one per-set result
    typedef struct {
        logic [IN_W-1:0] ax, ay, az, bx, by, bz;
        bit              mag, frz, last;
    } node_t;

    typedef struct {
        bit [OUT_W-1:0] norm;
        bit             any;
    } norm_result_t;

    // Tracks the running maximum per set and checks emitted norms in order
    class norm_scoreboard;
        bit           mag_en, frz_en;
        bit [63:0]    best_sq;
        bit           seen;
        norm_result_t pending[$];
        int           errors, requests, sets, empty_sets, masked, results;

        function void report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endfunction

        // low COMP_BITS bits, sign-extended
        function longint sext(logic [IN_W-1:0] v);
            longint r;
            r = longint'(v) & ((longint'(1) << COMP_BITS) - 1);
            if (v[COMP_BITS-1])
                r -= longint'(1) << COMP_BITS;
            return r;
        endfunction

        function bit [63:0] square(longint v);
            bit [63:0] m;
            m = (v < 0) ? -v : v;
            return m * m;
        endfunction

        // bitwise search for floor(sqrt(x))
        function bit [31:0] root_floor(bit [63:0] x);
            bit [31:0] r;
            bit [31:0] t;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (32'd1 << b);
                if ({32'd0, t} * {32'd0, t} <= x)
                    r = t;
            end
            return r;
        endfunction

        function void note_request(node_t n);
            longint       ax, ay, az, bx, by, bz;
            bit [63:0]    s;
            norm_result_t r;
            requests++;
            if ((mag_en && !n.mag) || (frz_en && n.frz)) begin
                masked++;
            end else begin
                ax = sext(n.ax); ay = sext(n.ay); az = sext(n.az);
                bx = sext(n.bx); by = sext(n.by); bz = sext(n.bz);
                s = square(ay * bz - az * by) + square(az * bx - ax * bz)
                    + square(ax * by - ay * bx);
                if (s > best_sq)
                    best_sq = s;
                seen = 1'b1;
            end
            if (n.last) begin
                sets++;
                r.norm = seen ? root_floor(best_sq) : '0;
                r.any  = seen;
                if (!seen)
                    empty_sets++;
                pending.push_back(r);
                best_sq = '0;
                seen    = 1'b0;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] norm, logic any);
            norm_result_t r;
            results++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result norm=%0d any=%0b", norm, any));
                return;
            end
            r = pending.pop_front();
            if (norm !== r.norm)
                report($sformatf("max_norm %0d, expected %0d", norm, r.norm));
            if (any !== r.any)
                report($sformatf("any_counted %0b, expected %0b", any, r.any));
        endfunction
    endclass

    // Block ports
    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [IN_W-1:0]    s_a_x         = '0;
    logic [IN_W-1:0]    s_a_y         = '0;
    logic [IN_W-1:0]    s_a_z         = '0;
    logic [IN_W-1:0]    s_b_x         = '0;
    logic [IN_W-1:0]    s_b_y         = '0;
    logic [IN_W-1:0]    s_b_z         = '0;
    logic               s_is_magnetic = 1'b0;
    logic               s_is_frozen   = 1'b0;
    logic               s_last_node   = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [OUT_W-1:0]   m_max_norm;
    logic               m_any_counted;

    norm_scoreboard sb = new;
    int             send_idle = 13;   // percent of cycles the sender holds off
    int             recv_idle = 54;   // percent of cycles the receiver stalls
    int unsigned    cycle_count = 0;

    masked_max_cross_product_norm_unit #(
        .COMPONENT_BITS(COMP_BITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_x(s_a_x), .s_a_y(s_a_y), .s_a_z(s_a_z),
        .s_b_x(s_b_x), .s_b_y(s_b_y), .s_b_z(s_b_z),
        .s_is_magnetic(s_is_magnetic), .s_is_frozen(s_is_frozen),
        .s_last_node(s_last_node),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_max_norm(m_max_norm), .m_any_counted(m_any_counted)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL masked_max_cross_product_norm_unit");
            $finish;
        end
    end

    // Receiver: random stalls, results checked at the accepting edge
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_max_norm, m_any_counted);
    end

    // Register write followed by a read-back; called and returns at a falling edge
    task automatic reg_write(logic idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge aclk) penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge aclk) penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
        if (rd[0] !== value[0])
            sb.report($sformatf("register %0b read back %0b, wrote %0b", idx, rd[0], value[0]));
    endtask

    task automatic set_masks(bit mag, bit frz);
        reg_write(REG_MAG_EN, {31'd0, mag});
        reg_write(REG_FRZ_EN, {31'd0, frz});
        sb.mag_en = mag;
        sb.frz_en = frz;
    endtask

    // Present one node and hold it until accepted; valid stays high on return
    task automatic send_node(node_t n);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_a_x = n.ax; s_a_y = n.ay; s_a_z = n.az;
        s_b_x = n.bx; s_b_y = n.by; s_b_z = n.bz;
        s_is_magnetic = n.mag; s_is_frozen = n.frz; s_last_node = n.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(n);
        @(negedge aclk);
    endtask

    // Let every expected result land, then let the unit settle
    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic node_t mk(int ax, int ay, int az, int bx, int by, int bz,
                                 bit mag, bit frz, bit last);
        node_t n;
        n.ax = ax[IN_W-1:0]; n.ay = ay[IN_W-1:0]; n.az = az[IN_W-1:0];
        n.bx = bx[IN_W-1:0]; n.by = by[IN_W-1:0]; n.bz = bz[IN_W-1:0];
        n.mag = mag; n.frz = frz; n.last = last;
        return n;
    endfunction

    // Mix of extremes, small values and full-range values
    function automatic logic [IN_W-1:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            3: return IN_W'($urandom_range(15) - 8);
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic node_t rand_node(bit last);
        node_t n;
        n.ax = rand_comp(); n.ay = rand_comp(); n.az = rand_comp();
        n.bx = rand_comp(); n.by = rand_comp(); n.bz = rand_comp();
        n.mag = 1'($urandom_range(1)); n.frz = 1'($urandom_range(1)); n.last = last;
        return n;
    endfunction

    initial begin
        int sent;
        int len;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed sets, masks off: unit vectors, extremes, parallel, zero
        set_masks(1'b0, 1'b0);
        send_node(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_node(mk(-32768, -32768, -32768, 32767, 32767, 32767, 0, 1, 1));
        send_node(mk(-32768, 32767, -32768, 32767, -32768, 32767, 1, 0, 0));
        send_node(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_node(mk(32767, 32767, -32768, -32768, 32767, 32767, 1, 1, 1));
        send_node(mk(0, 0, 0, -1, -1, -1, 0, 0, 1));
        send_node(mk(-32768, 0, 0, 0, -32768, 0, 1, 1, 1));
        send_node(mk(-32768, 32767, 0, 32767, 32767, -32768, 0, 0, 1));
        drain();

        // Directed sets, both masks on: all masked, masked last node
        set_masks(1'b1, 1'b1);
        send_node(mk(1000, -2000, 3000, 4, 5, 6, 0, 0, 0));
        send_node(mk(-32768, 32767, 5, 7, -32768, 32767, 1, 1, 0));
        send_node(mk(32767, 0, 0, 0, 32767, 0, 0, 1, 1));
        send_node(mk(1, 2, 3, 4, 5, 6, 1, 0, 0));
        send_node(mk(-32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 1));
        send_node(mk(1, 2, 3, 4, 5, 6, 1, 0, 1));
        send_node(mk(-32768, -32768, 32767, 32767, -32768, -32768, 1, 1, 1));
        drain();

        // Random sets: three idling patterns, each under all four mask settings
        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 13 : (mode == 1) ? 54 : 0;
            recv_idle = (mode == 0) ? 54 : (mode == 1) ? 13 : 0;
            for (int c = 0; c < 4; c++) begin
                set_masks(c[0], c[1]);
                sent = 0;
                while (sent < RAND_BUDGET) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(40, 17)
                                                   : $urandom_range(12, 1);
                    for (int i = 0; i < len; i++)
                        send_node(rand_node(i == len - 1));
                    sent += len;
                end
                drain();
            end
        end

        $display("Covered %0d requests in %0d sets (%0d empty sets, %0d nodes masked).",
                 sb.requests, sb.sets, sb.empty_sets, sb.masked);
        $display("All four mask settings under three sender/receiver idling patterns, %0d results.",
                 sb.results);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS masked_max_cross_product_norm_unit");
        else
            $display("FAIL masked_max_cross_product_norm_unit");
        $finish;
    end

endmodule

// File: files.f
sv/mmcpn_pkg.sv
sv/mmcpn_datapath.sv
sv/mmcpn_ctrl.sv
sv/masked_max_cross_product_norm_unit.sv
bench/masked_max_cross_product_norm_unit_tb.sv
